@@ design/salc_pkg.sv @@
// Shared constants and types for the set-associative LRU cache model.
// No dependencies; salc_scan_step and set_assoc_lru_cache_sim refer to it by scoped names.
package salc_pkg;

	// Default sizing handed to the top level parameters
	localparam int MAX_SET_BITS_DEF = 8;
	localparam int MAX_WAYS_DEF     = 8;
	localparam int COUNT_WIDTH_DEF  = 32;

	// Fixed field widths
	localparam int ADDR_W     = 64;
	localparam int TAG_W      = 64;
	localparam int RES_W      = 32;
	localparam int WAY_MAX_W  = 5;   // way index or rank for up to 32 ways
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 6;

	// Access kinds
	localparam logic [1:0] ACT_LOAD   = 2'd0;
	localparam logic [1:0] ACT_STORE  = 2'd1;
	localparam logic [1:0] ACT_MODIFY = 2'd2;

	// Access outcomes
	localparam logic [1:0] OUT_HIT   = 2'd0;
	localparam logic [1:0] OUT_FILL  = 2'd1;
	localparam logic [1:0] OUT_EVICT = 2'd2;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_SET_BITS   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BLOCK_BITS = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_WAYS       = 2'd2;

	// Running result of the way scan
	typedef struct packed {
		logic                 hit;
		logic [WAY_MAX_W-1:0] hit_way;
		logic                 inv;
		logic [WAY_MAX_W-1:0] inv_way;
		logic [WAY_MAX_W-1:0] vic_way;
		logic [WAY_MAX_W-1:0] oldest;
	} scan_acc_t;

endpackage

@@ design/salc_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// Standalone; no package use.
module salc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		// hold the last read word until the next read
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

@@ design/salc_scan_step.sv @@
// One step of the way scan: tag compare, first-invalid pick and LRU victim track.
// Uses salc_pkg for the scan accumulator type and widths.
module salc_scan_step (
	input  logic                          first,
	input  logic [salc_pkg::WAY_MAX_W-1:0] way_idx,
	input  logic                          way_valid,
	input  logic [salc_pkg::TAG_W-1:0]     way_tag,
	input  logic [salc_pkg::WAY_MAX_W-1:0] way_age,
	input  logic [salc_pkg::TAG_W-1:0]     key_tag,
	input  salc_pkg::scan_acc_t            acc_in,
	output salc_pkg::scan_acc_t            acc_out
);

	salc_pkg::scan_acc_t base;

	always_comb begin
		// restart the running result on way zero
		base = first ? '0 : acc_in;
		acc_out = base;
		if (way_valid && (way_tag == key_tag)) begin
			acc_out.hit     = 1'b1;
			acc_out.hit_way = way_idx;
		end
		if (!base.inv && !way_valid) begin
			acc_out.inv     = 1'b1;
			acc_out.inv_way = way_idx;
		end
		// ties go to the higher way
		if (way_age >= base.oldest) begin
			acc_out.vic_way = way_idx;
			acc_out.oldest  = way_age;
		end
	end

endmodule

@@ design/set_assoc_lru_cache_sim.sv @@
// Tag-only set-associative cache with true LRU replacement and saturating hit, miss and
// eviction totals; depends on salc_pkg, salc_ram and salc_scan_step.
//
// Each item is a load, store or modify on a 64-bit address; load and store give one result,
// modify gives two (last marks the second), and action code 3 is dropped with no result.
// One access is a row read, a scan of the ways one at a time through the single tag
// compare unit (stopping early on a hit, otherwise all ways in use), and a write-back.
// A modify runs two accesses back to back; in_stall stays high from after the accept
// until the last write-back. A finished result sits in an output register, so a new
// item may be taken while it waits; the write-back waits only while an earlier result
// is still held. Each set is one wide RAM row holding valid, rank and tag for every way.
// A per-set flag, cleared at reset, marks rows written since reset; an unmarked row
// reads as all ways invalid with ranks in way order, so there is no clearing pass after
// reset. Configuration writes are taken at any cycle but are meant for idle periods;
// set_bits and ways are clamped as the access needs them.
module set_assoc_lru_cache_sim #(
	parameter int MAX_SET_BITS = salc_pkg::MAX_SET_BITS_DEF,
	parameter int MAX_WAYS     = salc_pkg::MAX_WAYS_DEF,
	parameter int COUNT_WIDTH  = salc_pkg::COUNT_WIDTH_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// input items
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic [1:0]                      action,
	input  logic [salc_pkg::ADDR_W-1:0]     address,
	// result items
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [1:0]                      outcome,
	output logic                            last,
	output logic [salc_pkg::RES_W-1:0]      hits_so_far,
	output logic [salc_pkg::RES_W-1:0]      misses_so_far,
	output logic [salc_pkg::RES_W-1:0]      evictions_so_far,
	// configuration writes
	input  logic                            cfg_wr_en,
	input  logic [salc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [salc_pkg::CFG_DATA_W-1:0] cfg_data
);

	localparam int NUM_SETS = 1 << MAX_SET_BITS;
	localparam int SET_W    = MAX_SET_BITS;
	localparam int WAY_W    = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
	localparam int SB_W     = $clog2(MAX_SET_BITS + 1);
	localparam int TAG_W    = salc_pkg::TAG_W;
	localparam int ENT_W    = 1 + WAY_W + TAG_W;
	localparam int ROW_W    = MAX_WAYS * ENT_W;

	// sequencer states
	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_READ = 2'd1;
	localparam logic [1:0] ST_SCAN = 2'd2;
	localparam logic [1:0] ST_UPD  = 2'd3;

	logic [1:0]             state_q;
	logic [3:0]             set_bits_q;
	logic [5:0]             block_bits_q;
	logic [3:0]             ways_q;

	logic [TAG_W-1:0]       tag_q;
	logic [SET_W-1:0]       set_q;
	logic                   mod_q;
	logic [WAY_W-1:0]       w_q;
	salc_pkg::scan_acc_t    acc_q;
	salc_pkg::scan_acc_t    acc_next;
	logic [NUM_SETS-1:0]    row_ok_q;

	logic [COUNT_WIDTH-1:0] hit_cnt_q;
	logic [COUNT_WIDTH-1:0] miss_cnt_q;
	logic [COUNT_WIDTH-1:0] evict_cnt_q;
	logic [COUNT_WIDTH-1:0] hit_nx;
	logic [COUNT_WIDTH-1:0] miss_nx;
	logic [COUNT_WIDTH-1:0] evict_nx;

	logic                   out_valid_q;
	logic [1:0]             outcome_q;
	logic                   last_q;
	logic [salc_pkg::RES_W-1:0] hits_q;
	logic [salc_pkg::RES_W-1:0] misses_q;
	logic [salc_pkg::RES_W-1:0] evicts_q;

	logic [SB_W-1:0]        sb;
	logic [6:0]             shift_sum;
	logic [salc_pkg::ADDR_W-1:0] addr_sh;
	logic [TAG_W-1:0]       tag_d;
	logic [SET_W-1:0]       set_d;
	logic [WAY_W-1:0]       nw_m1;

	logic [ROW_W-1:0]       rd_row;
	logic [ROW_W-1:0]       wr_row;
	logic                   row_ok;
	logic                   way_valid [MAX_WAYS];
	logic [WAY_W-1:0]       way_age   [MAX_WAYS];
	logic [TAG_W-1:0]       way_tag   [MAX_WAYS];

	logic                   in_fire;
	logic                   res_fire;
	logic [WAY_W-1:0]       ch_way;
	logic [WAY_W-1:0]       ch_age;
	logic [1:0]             outcome_d;

	// Clamp the configured sizes and split the incoming address
	always_comb begin
		sb = (32'(set_bits_q) > MAX_SET_BITS) ? SB_W'(MAX_SET_BITS) : SB_W'(set_bits_q);
		shift_sum = 7'(sb) + 7'(block_bits_q);
		tag_d = (shift_sum >= 7'd64) ? '0 : (address >> shift_sum[5:0]);
		addr_sh = address >> block_bits_q;
		for (int i = 0; i < SET_W; i++) begin
			set_d[i] = addr_sh[i] & (32'(sb) > i);
		end
		if (ways_q == 4'd0) begin
			nw_m1 = '0;
		end else if (32'(ways_q) > MAX_WAYS) begin
			nw_m1 = WAY_W'(MAX_WAYS - 1);
		end else begin
			nw_m1 = WAY_W'(ways_q - 4'd1);
		end
	end

	assign in_stall = (state_q != ST_IDLE);
	assign in_fire  = in_valid && !in_stall;
	assign res_fire = (state_q == ST_UPD) && (!out_valid_q || !out_stall);

	// Set rows: one RAM word per set
	salc_ram #(
		.WIDTH (ROW_W),
		.DEPTH (NUM_SETS)
	) u_rows (
		.clk     (clk),
		.wr_en   (res_fire),
		.wr_addr (set_q),
		.wr_data (wr_row),
		.rd_en   (state_q == ST_READ),
		.rd_addr (set_q),
		.rd_data (rd_row)
	);

	// Unpack the row; a row not written since reset reads as its reset contents
	assign row_ok = row_ok_q[set_q];

	always_comb begin
		for (int w = 0; w < MAX_WAYS; w++) begin
			way_tag[w]   = rd_row[w*ENT_W +: TAG_W];
			way_age[w]   = row_ok ? rd_row[w*ENT_W + TAG_W +: WAY_W] : WAY_W'(w);
			way_valid[w] = row_ok & rd_row[w*ENT_W + ENT_W - 1];
		end
	end

	// Shared compare unit, stepped one way per cycle
	salc_scan_step u_step (
		.first     (w_q == '0),
		.way_idx   (salc_pkg::WAY_MAX_W'(w_q)),
		.way_valid (way_valid[w_q]),
		.way_tag   (way_tag[w_q]),
		.way_age   (salc_pkg::WAY_MAX_W'(way_age[w_q])),
		.key_tag   (tag_q),
		.acc_in    (acc_q),
		.acc_out   (acc_next)
	);

	// Pick the way to touch: hit way, else first invalid way, else LRU victim
	always_comb begin
		if (acc_q.hit) begin
			ch_way    = WAY_W'(acc_q.hit_way);
			outcome_d = salc_pkg::OUT_HIT;
		end else if (acc_q.inv) begin
			ch_way    = WAY_W'(acc_q.inv_way);
			outcome_d = salc_pkg::OUT_FILL;
		end else begin
			ch_way    = WAY_W'(acc_q.vic_way);
			outcome_d = salc_pkg::OUT_EVICT;
		end
		ch_age = way_age[ch_way];
	end

	// Rebuild the row: touched way goes to rank zero, younger ways age by one
	always_comb begin
		for (int w = 0; w < MAX_WAYS; w++) begin
			if (WAY_W'(w) == ch_way) begin
				wr_row[w*ENT_W +: ENT_W] = {1'b1, {WAY_W{1'b0}}, tag_q};
			end else if (way_age[w] < ch_age) begin
				wr_row[w*ENT_W +: ENT_W] = {way_valid[w], way_age[w] + WAY_W'(1), way_tag[w]};
			end else begin
				wr_row[w*ENT_W +: ENT_W] = {way_valid[w], way_age[w], way_tag[w]};
			end
		end
	end

	// Saturating totals after this access
	always_comb begin
		hit_nx   = hit_cnt_q;
		miss_nx  = miss_cnt_q;
		evict_nx = evict_cnt_q;
		if (acc_q.hit) begin
			if (hit_cnt_q != '1) hit_nx = hit_cnt_q + COUNT_WIDTH'(1);
		end else begin
			if (miss_cnt_q != '1) miss_nx = miss_cnt_q + COUNT_WIDTH'(1);
			if (!acc_q.inv && (evict_cnt_q != '1)) evict_nx = evict_cnt_q + COUNT_WIDTH'(1);
		end
	end

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			set_bits_q   <= 4'd1;
			block_bits_q <= 6'd4;
			ways_q       <= 4'd1;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				salc_pkg::REG_SET_BITS:   set_bits_q   <= cfg_data[3:0];
				salc_pkg::REG_BLOCK_BITS: block_bits_q <= cfg_data;
				salc_pkg::REG_WAYS:       ways_q       <= cfg_data[3:0];
				default: ;
			endcase
		end
	end

	// Sequencer, row flags, totals and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			mod_q       <= 1'b0;
			row_ok_q    <= '0;
			hit_cnt_q   <= '0;
			miss_cnt_q  <= '0;
			evict_cnt_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						case (action)
							salc_pkg::ACT_LOAD, salc_pkg::ACT_STORE: begin
								mod_q   <= 1'b0;
								state_q <= ST_READ;
							end
							salc_pkg::ACT_MODIFY: begin
								mod_q   <= 1'b1;
								state_q <= ST_READ;
							end
							default: ;
						endcase
					end
				end
				ST_READ: begin
					state_q <= ST_SCAN;
				end
				ST_SCAN: begin
					// stop on a hit or after the last way in use
					if (acc_next.hit || (w_q == nw_m1)) begin
						state_q <= ST_UPD;
					end
				end
				ST_UPD: begin
					if (res_fire) begin
						row_ok_q[set_q] <= 1'b1;
						hit_cnt_q       <= hit_nx;
						miss_cnt_q      <= miss_nx;
						evict_cnt_q     <= evict_nx;
						if (mod_q) begin
							mod_q   <= 1'b0;
							state_q <= ST_READ;
						end else begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
			// load a finished result, else drop the held one once taken
			if (res_fire) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (in_fire) begin
			tag_q <= tag_d;
			set_q <= set_d;
		end
		if (state_q == ST_READ) begin
			w_q <= '0;
		end else if (state_q == ST_SCAN) begin
			acc_q <= acc_next;
			w_q   <= w_q + WAY_W'(1);
		end
		if (res_fire) begin
			outcome_q <= outcome_d;
			last_q    <= !mod_q;
			hits_q    <= salc_pkg::RES_W'(hit_nx);
			misses_q  <= salc_pkg::RES_W'(miss_nx);
			evicts_q  <= salc_pkg::RES_W'(evict_nx);
		end
	end

	assign out_valid        = out_valid_q;
	assign outcome          = outcome_q;
	assign last             = last_q;
	assign hits_so_far      = hits_q;
	assign misses_so_far    = misses_q;
	assign evictions_so_far = evicts_q;

	// Scan never reaches past the ways in use
	a_scan_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN) |-> (w_q <= nw_m1))
		else $error("way scan ran past the ways in use");

	// A hit always lands on a valid way
	a_hit_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_UPD && acc_q.hit) |-> way_valid[ch_way])
		else $error("hit selected an invalid way");

	// The second access of a modify starts right after the first result
	a_modify_second: assert property (@(posedge clk) disable iff (!arst_n)
		(res_fire && mod_q) |=> (state_q == ST_READ && !mod_q))
		else $error("second access of modify not started");

	// An accepted access item starts a row read
	a_start_read: assert property (@(posedge clk) disable iff (!arst_n)
		(in_fire && (action == salc_pkg::ACT_LOAD || action == salc_pkg::ACT_STORE ||
			action == salc_pkg::ACT_MODIFY)) |=> (state_q == ST_READ))
		else $error("accepted item did not start an access");

	// At most one of the hit and miss totals advances per write-back
	a_one_bump: assert property (@(posedge clk) disable iff (!arst_n)
		res_fire |=> ($countones({hit_cnt_q != $past(hit_cnt_q),
			miss_cnt_q != $past(miss_cnt_q)}) <= 1))
		else $error("hit and miss totals both advanced");

endmodule
